[src/sbfae_pkg.sv]
// ----------------------------------------------------------------------------
// sbfae_pkg
// Shared types, constants and arithmetic steps of the spectral bin
// frequency and amplitude estimator.
// ----------------------------------------------------------------------------
package sbfae_pkg;

   localparam int DEF_MAX_BINS = 4096;

   localparam int SAMPLE_W  = 32;
   localparam int CFG_W     = 13;
   localparam logic [CFG_W-1:0] CFG_RESET = 13'd512;
   localparam int MIN_BINS  = 4;
   localparam int FREQ_W    = 32;
   localparam int AMP_W     = 32;
   localparam int OUT_BIN_W = 12;

   // Operand widths: twice the residue needs 35 bits, shifted magnitudes 31.
   localparam int WIDE_W  = 35;
   localparam int SHR_W   = 2;
   localparam int MAG_W   = 31;
   localparam int PROD_W  = 62;
   localparam int NUM_W   = 65;
   localparam int DEN_W   = 64;
   localparam int REM_W   = 65;
   localparam int QUO_W   = 18;
   localparam int ROOT_W  = 64;
   localparam int AMPN_W  = 36;

   // Sequencer step counts.
   localparam int CNT_W        = 5;
   localparam int MUL_CYCLES   = 5;
   localparam int MUL_TERMS    = 4;
   localparam int DIV_CYCLES   = 18;
   localparam int INT_STEPS    = 2;
   localparam int AMP_CYCLES   = 18;
   localparam int STEPS_PER_CY = 2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ZERO = 2'd0;
   localparam kind_type KIND_NONE = 2'd1;
   localparam kind_type KIND_EST  = 2'd2;

   typedef logic [1:0] term_type;
   localparam term_type TERM_DR_R2 = 2'd0;
   localparam term_type TERM_DI_I2 = 2'd1;
   localparam term_type TERM_R2_R2 = 2'd2;
   localparam term_type TERM_I2_I2 = 2'd3;

   typedef struct packed {
      logic     mul_en;
      term_type mul_sel;
      logic     prep;
      logic     div_step;
      logic     div_first;
      logic     amp_init;
      logic     amp_step;
      logic     out_load;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     out_free;
   } dp_status_type;

   typedef struct packed {
      logic [ROOT_W-1:0] x;
      logic [ROOT_W-1:0] res;
      logic [ROOT_W-1:0] bit_mask;
   } root_type;

   // One digit of the bitwise integer square root; idle once the mask is spent.
   function automatic root_type root_step(root_type a);
      root_type          r;
      logic [ROOT_W-1:0] t;
      r = a;
      t = a.res + a.bit_mask;
      if (a.bit_mask != '0) begin
         if (a.x >= t) begin
            r.x   = a.x - t;
            r.res = (a.res >> 1) + a.bit_mask;
         end else begin
            r.res = a.res >> 1;
         end
         r.bit_mask = a.bit_mask >> 2;
      end
      return r;
   endfunction

endpackage

[src/spectral_bin_freq_amp_estimator.sv]
// ----------------------------------------------------------------------------
// spectral_bin_freq_amp_estimator
// Estimates frequency and amplitude of each interior spectral bin from the
// bin and its two neighbors; results trail the input by one bin.
// ----------------------------------------------------------------------------
// Sequence: an estimated bin passes the single shared multiplier, then
//   the detune divider running beside the square root, then the amplitude
//   divider, all two digits per cycle at most. Bin zero goes straight to
//   the result register; the second bin of a frame gives no transaction.
//   A new bin is held off until the previous one enters the result register.
// Reset: synchronous, active high; clears history, position, bin_count to 512.
// ----------------------------------------------------------------------------
module spectral_bin_freq_amp_estimator #(
   parameter int MAX_BINS = sbfae_pkg::DEF_MAX_BINS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration write
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [sbfae_pkg::CFG_W-1:0]      csr_bin_count,
   // input bins
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [sbfae_pkg::SAMPLE_W-1:0]   req_bin_real,
   input  logic signed [sbfae_pkg::SAMPLE_W-1:0]   req_bin_imag,
   // results
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [sbfae_pkg::FREQ_W-1:0]     rsp_est_frequency,
   output logic        [sbfae_pkg::AMP_W-1:0]      rsp_est_amplitude,
   output logic        [sbfae_pkg::OUT_BIN_W-1:0]  rsp_out_bin
);

   sbfae_pkg::dp_cmd_type    cmd;
   sbfae_pkg::dp_status_type status;
   logic                     busy;
   logic                     req_accept;

   // The register is always writable; writes land only while idle by contract.
   assign csr_ready = 1'b1;

   // Hold the input off while a bin is in flight; the result register lets
   // a new bin enter while the previous result still waits downstream.
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;

   sbfae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   sbfae_dp #(
      .MAX_BINS (MAX_BINS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid),
      .csr_data   (csr_bin_count),
      .req_accept (req_accept),
      .req_real   (req_bin_real),
      .req_imag   (req_bin_imag),
      .cmd        (cmd),
      .status     (status),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_freq   (rsp_est_frequency),
      .rsp_amp    (rsp_est_amplitude),
      .rsp_bin    (rsp_out_bin)
   );

endmodule

[src/sbfae_ctrl.sv]
// ----------------------------------------------------------------------------
// sbfae_ctrl
// Sequencer: multiply, divide/root and amplitude divide phases per bin.
// ----------------------------------------------------------------------------
module sbfae_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_accept,
   input  sbfae_pkg::dp_status_type  status,
   output sbfae_pkg::dp_cmd_type     cmd,
   output logic                      busy
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_PREP  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_AINIT = 3'd4;
   localparam logic [2:0] ST_AMP   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [sbfae_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_accept) begin
               unique case (status.kind)
                  sbfae_pkg::KIND_ZERO: state_in = ST_OUT;
                  sbfae_pkg::KIND_EST:  state_in = ST_MUL;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul_en  = (cnt_ff < sbfae_pkg::CNT_W'(sbfae_pkg::MUL_TERMS));
            cmd.mul_sel = cnt_ff[1:0];
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == sbfae_pkg::CNT_W'(sbfae_pkg::MUL_CYCLES - 1)) begin
               cnt_in   = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff < sbfae_pkg::CNT_W'(sbfae_pkg::INT_STEPS));
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == sbfae_pkg::CNT_W'(sbfae_pkg::DIV_CYCLES - 1)) begin
               cnt_in   = '0;
               state_in = ST_AINIT;
            end
         end
         ST_AINIT: begin
            cmd.amp_init = 1'b1;
            state_in     = ST_AMP;
         end
         ST_AMP: begin
            cmd.amp_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == sbfae_pkg::CNT_W'(sbfae_pkg::AMP_CYCLES - 1)) begin
               cnt_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[src/sbfae_dp.sv]
// ----------------------------------------------------------------------------
// sbfae_dp
// Datapath: bin history, shared multiplier, detune divider, square root,
// amplitude divider and result register.
// ----------------------------------------------------------------------------
module sbfae_dp #(
   parameter int MAX_BINS = sbfae_pkg::DEF_MAX_BINS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic        [sbfae_pkg::CFG_W-1:0]      csr_data,
   input  logic                                    req_accept,
   input  logic signed [sbfae_pkg::SAMPLE_W-1:0]   req_real,
   input  logic signed [sbfae_pkg::SAMPLE_W-1:0]   req_imag,
   input  sbfae_pkg::dp_cmd_type                   cmd,
   output sbfae_pkg::dp_status_type                status,
   input  logic                                    rsp_stall,
   output logic                                    rsp_valid,
   output logic signed [sbfae_pkg::FREQ_W-1:0]     rsp_freq,
   output logic        [sbfae_pkg::AMP_W-1:0]      rsp_amp,
   output logic        [sbfae_pkg::OUT_BIN_W-1:0]  rsp_bin
);

   localparam int LEN_W = $clog2(MAX_BINS + 1);
   localparam int POS_W = $clog2(MAX_BINS);
   localparam int DVS_W = LEN_W + 1;

   localparam int SW  = sbfae_pkg::SAMPLE_W;
   localparam int WW  = sbfae_pkg::WIDE_W;
   localparam int MW  = sbfae_pkg::MAG_W;
   localparam int PW  = sbfae_pkg::PROD_W;
   localparam int NW  = sbfae_pkg::NUM_W;
   localparam int DW  = sbfae_pkg::DEN_W;
   localparam int RW  = sbfae_pkg::REM_W;
   localparam int QW  = sbfae_pkg::QUO_W;
   localparam int AW  = sbfae_pkg::AMPN_W;

   // Configuration and frame history
   logic [sbfae_pkg::CFG_W-1:0] cfg_ff;
   logic signed [SW-1:0]        older_re_ff, older_im_ff, prior_re_ff, prior_im_ff;
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic [LEN_W-1:0]            len;
   logic [31:0]                 cfg32;
   sbfae_pkg::kind_type         pos_kind;

   always_comb begin
      cfg32 = 32'(cfg_ff);
      if (cfg32 < 32'(sbfae_pkg::MIN_BINS)) begin
         len = LEN_W'(sbfae_pkg::MIN_BINS);
      end else if (cfg32 > 32'(MAX_BINS)) begin
         len = LEN_W'(MAX_BINS);
      end else begin
         len = LEN_W'(cfg32);
      end
      if (32'(pos_ff) >= 32'(len) - 32'd1) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
      if (pos_ff == '0) begin
         pos_kind = sbfae_pkg::KIND_ZERO;
      end else if (pos_ff == POS_W'(1)) begin
         pos_kind = sbfae_pkg::KIND_NONE;
      end else begin
         pos_kind = sbfae_pkg::KIND_EST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= sbfae_pkg::CFG_RESET;
         older_re_ff <= '0;
         older_im_ff <= '0;
         prior_re_ff <= '0;
         prior_im_ff <= '0;
         pos_ff      <= '0;
      end else begin
         if (csr_write) begin
            cfg_ff <= csr_data;
         end
         if (req_accept) begin
            older_re_ff <= prior_re_ff;
            older_im_ff <= prior_im_ff;
            prior_re_ff <= req_real;
            prior_im_ff <= req_imag;
            pos_ff      <= pos_in;
         end
      end
   end

   // Operand capture: twice the residue, neighbor difference, common scaling
   logic signed [WW-1:0] r2, i2, dr, di;
   logic        [WW-1:0] mr2, mi2, mdr, mdi, mmax;
   logic [sbfae_pkg::SHR_W-1:0] shr;

   function automatic logic [WW-1:0] wmag(logic signed [WW-1:0] v);
      return v[WW-1] ? WW'(-v) : WW'(v);
   endfunction

   always_comb begin
      r2   = (WW'(prior_re_ff) <<< 1) - WW'(older_re_ff) - WW'(req_real);
      i2   = (WW'(prior_im_ff) <<< 1) - WW'(older_im_ff) - WW'(req_imag);
      dr   = WW'(older_re_ff) - WW'(req_real);
      di   = WW'(older_im_ff) - WW'(req_imag);
      mr2  = wmag(r2);
      mi2  = wmag(i2);
      mdr  = wmag(dr);
      mdi  = wmag(di);
      mmax = mr2;
      if (mi2 > mmax) mmax = mi2;
      if (mdr > mmax) mmax = mdr;
      if (mdi > mmax) mmax = mdi;
      priority if (mmax[33]) begin
         shr = 2'd3;
      end else if (mmax[32]) begin
         shr = 2'd2;
      end else if (mmax[31]) begin
         shr = 2'd1;
      end else begin
         shr = 2'd0;
      end
   end

   logic [MW-1:0]               r2_ff, i2_ff, dr_ff, di_ff;
   logic                        r2_neg_ff, i2_neg_ff, dr_neg_ff, di_neg_ff;
   logic [sbfae_pkg::SHR_W-1:0] shr_ff;
   logic [POS_W-1:0]            idx_ff;
   logic                        zero_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         r2_ff     <= MW'(mr2 >> shr);
         i2_ff     <= MW'(mi2 >> shr);
         dr_ff     <= MW'(mdr >> shr);
         di_ff     <= MW'(mdi >> shr);
         r2_neg_ff <= r2[WW-1];
         i2_neg_ff <= i2[WW-1];
         dr_neg_ff <= dr[WW-1];
         di_neg_ff <= di[WW-1];
         shr_ff    <= shr;
         zero_ff   <= (pos_ff == '0);
         idx_ff    <= (pos_ff == '0) ? '0 : pos_ff - 1'b1;
      end
   end

   // Shared multiplier, registered product, then accumulate
   logic [MW-1:0] mul_a, mul_b;
   logic          mul_neg;

   always_comb begin
      unique case (cmd.mul_sel)
         sbfae_pkg::TERM_DR_R2: begin
            mul_a = dr_ff; mul_b = r2_ff; mul_neg = dr_neg_ff ^ r2_neg_ff;
         end
         sbfae_pkg::TERM_DI_I2: begin
            mul_a = di_ff; mul_b = i2_ff; mul_neg = di_neg_ff ^ i2_neg_ff;
         end
         sbfae_pkg::TERM_R2_R2: begin
            mul_a = r2_ff; mul_b = r2_ff; mul_neg = 1'b0;
         end
         default: begin
            mul_a = i2_ff; mul_b = i2_ff; mul_neg = 1'b0;
         end
      endcase
   end

   logic [PW-1:0]        prod_ff;
   logic                 prod_neg_ff, prod_den_ff, prod_vld_ff;
   logic signed [NW-1:0] n_ff;
   logic [DW-1:0]        d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
      end
      prod_ff     <= PW'(mul_a) * PW'(mul_b);
      prod_neg_ff <= mul_neg;
      prod_den_ff <= cmd.mul_sel[1];
      if (req_accept) begin
         n_ff <= '0;
         d_ff <= '0;
      end else if (prod_vld_ff) begin
         if (prod_den_ff) begin
            d_ff <= d_ff + DW'(prod_ff);
         end else if (prod_neg_ff) begin
            n_ff <= n_ff - NW'(prod_ff);
         end else begin
            n_ff <= n_ff + NW'(prod_ff);
         end
      end
   end

   // Detune division and square root of the power
   logic [DW-1:0]        a_ff;
   logic                 n_neg_ff;
   logic [RW-1:0]        rem_ff, rem_in, rem_sh;
   logic [QW-1:0]        q_ff, q_in;
   sbfae_pkg::root_type  root_ff, root_mid, root_in;
   logic                 ge;

   always_comb begin
      rem_sh = rem_ff << 1;
      if (cmd.div_first) begin
         ge     = (rem_ff >= RW'(d_ff));
         rem_in = ge ? rem_ff - RW'(d_ff) : rem_ff;
         q_in   = q_ff + QW'(ge);
      end else begin
         ge     = (rem_sh >= RW'(d_ff));
         rem_in = ge ? rem_sh - RW'(d_ff) : rem_sh;
         q_in   = {q_ff[QW-2:0], ge};
      end
      root_mid = sbfae_pkg::root_step(root_ff);
      root_in  = sbfae_pkg::root_step(root_mid);
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         n_neg_ff         <= n_ff[NW-1];
         a_ff             <= n_ff[NW-1] ? DW'(-n_ff) : DW'(n_ff);
         rem_ff           <= n_ff[NW-1] ? RW'(-n_ff) : RW'(n_ff);
         q_ff             <= '0;
         root_ff.x        <= d_ff;
         root_ff.res      <= '0;
         root_ff.bit_mask <= sbfae_pkg::ROOT_W'(1) << (sbfae_pkg::ROOT_W - 2);
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         root_ff <= root_in;
      end
   end

   // Amplitude: restoring division of the scaled root by twice the frame length
   logic [DVS_W-1:0] divisor;
   logic [DVS_W:0]   arem_ff, arem_in;
   logic [AW-1:0]    aq_ff, aq_in;
   logic [DVS_W:0]   arem_sh;
   logic             age;

   assign divisor = {len, 1'b0};

   always_comb begin
      arem_in = arem_ff;
      aq_in   = aq_ff;
      for (int k = 0; k < sbfae_pkg::STEPS_PER_CY; k++) begin
         arem_sh = {arem_in[DVS_W-1:0], aq_in[AW-1]};
         age     = (arem_sh >= (DVS_W+1)'(divisor));
         arem_in = age ? arem_sh - (DVS_W+1)'(divisor) : arem_sh;
         aq_in   = {aq_in[AW-2:0], age};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.amp_init) begin
         arem_ff <= '0;
         aq_ff   <= AW'(root_ff.res[31:0]) << shr_ff;
      end else if (cmd.amp_step) begin
         arem_ff <= arem_in;
         aq_ff   <= aq_in;
      end
   end

   // Result register
   logic                 reject;
   logic signed [31:0]   det;
   logic [31:0]          amp_sat;
   logic                 rsp_valid_ff;
   logic signed [sbfae_pkg::FREQ_W-1:0]  freq_ff;
   logic [sbfae_pkg::AMP_W-1:0]          amp_ff;
   logic [sbfae_pkg::OUT_BIN_W-1:0]      bin_ff;

   always_comb begin
      reject  = zero_ff || (d_ff == '0) || ({1'b0, a_ff} > {d_ff, 1'b0});
      det     = n_neg_ff ? -32'(q_ff) : 32'(q_ff);
      amp_sat = (aq_ff[AW-1:32] != '0) ? '1 : aq_ff[31:0];
   end

   assign status = '{kind: pos_kind, out_free: (!rsp_valid_ff || !rsp_stall)};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         freq_ff <= reject ? '0 : (32'(idx_ff) << 16) + det;
         amp_ff  <= reject ? '0 : amp_sat;
         bin_ff  <= sbfae_pkg::OUT_BIN_W'(idx_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_freq  = freq_ff;
   assign rsp_amp   = amp_ff;
   assign rsp_bin   = bin_ff;

endmodule
